/* rtl/mpd_pkg.sv */
// Shared types for the MQTT packet deframer: byte roles and the per-byte result.
package mpd_pkg;

    typedef enum logic [2:0] {
        ROLE_CONTROL   = 3'd0,
        ROLE_LENGTH    = 3'd1,
        ROLE_TOPIC_LEN = 3'd2,
        ROLE_TOPIC     = 3'd3,
        ROLE_PAYLOAD   = 3'd4,
        ROLE_SKIPPED   = 3'd5
    } t_role;

    localparam logic [3:0] TYPE_CONNACK = 4'd2;
    localparam logic [3:0] TYPE_PUBLISH = 4'd3;

    typedef struct packed {
        logic [7:0] byte_out;
        t_role      role;
        logic [3:0] msg_type;
        logic       packet_end;
        logic       connected;
        logic       malformed;
    } t_result;

endpackage

/* rtl/mpd_parser.sv */
// Per-byte MQTT fixed-header and PUBLISH body parser: state registers and next-state logic.
module mpd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_data_byte,
    input  logic              i_link_up,
    output mpd_pkg::t_result  o_result
);
    import mpd_pkg::*;

    typedef enum logic [2:0] {
        PH_CTRL    = 3'd0,
        PH_LEN     = 3'd1,
        PH_TLEN_HI = 3'd2,
        PH_TLEN_LO = 3'd3,
        PH_TOPIC   = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_SKIP    = 3'd6
    } t_phase;

    t_phase      r_phase,        n_phase;
    logic [3:0]  r_kind,         n_kind;
    logic [27:0] r_length_accum, n_length_accum;
    logic [2:0]  r_length_count, n_length_count;
    logic [27:0] r_body_left,    n_body_left;
    logic [15:0] r_topic_left,   n_topic_left;
    logic [7:0]  r_topic_high,   n_topic_high;
    logic [1:0]  r_body_index,   n_body_index;
    logic        r_session_up,   n_session_up;

    logic [27:0] body_dec;
    logic [27:0] len_part;
    logic [15:0] topic_val;
    t_role       role;
    logic        pkt_end;
    logic        bad;

    assign body_dec  = (r_body_left != '0) ? r_body_left - 28'd1 : r_body_left;
    assign topic_val = {r_topic_high, i_data_byte};

    always_comb begin
        case (r_length_count[1:0])
            2'd0:    len_part = {21'd0, i_data_byte[6:0]};
            2'd1:    len_part = {14'd0, i_data_byte[6:0], 7'd0};
            2'd2:    len_part = {7'd0, i_data_byte[6:0], 14'd0};
            default: len_part = {i_data_byte[6:0], 21'd0};
        endcase
    end

    always_comb begin
        n_phase        = r_phase;
        n_kind         = r_kind;
        n_length_accum = r_length_accum;
        n_length_count = r_length_count;
        n_body_left    = r_body_left;
        n_topic_left   = r_topic_left;
        n_topic_high   = r_topic_high;
        n_body_index   = r_body_index;
        n_session_up   = i_link_up ? r_session_up : 1'b0;
        role           = ROLE_CONTROL;
        pkt_end        = 1'b0;
        bad            = 1'b0;

        unique case (r_phase)
            PH_LEN: begin
                role           = ROLE_LENGTH;
                n_length_accum = r_length_accum | len_part;
                n_length_count = r_length_count + 3'd1;
                if (!i_data_byte[7] || n_length_count >= 3'd4) begin
                    n_body_left  = n_length_accum;
                    n_body_index = '0;
                    if (n_length_accum == '0) begin
                        pkt_end = 1'b1;
                        n_phase = PH_CTRL;
                    end else if (r_kind == TYPE_PUBLISH) begin
                        n_phase = PH_TLEN_HI;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_TLEN_HI: begin
                role         = ROLE_TOPIC_LEN;
                n_topic_high = i_data_byte;
                n_body_left  = body_dec;
                if (body_dec == '0) begin
                    bad     = 1'b1;
                    pkt_end = 1'b1;
                    n_phase = PH_CTRL;
                end else begin
                    n_phase = PH_TLEN_LO;
                end
            end
            PH_TLEN_LO: begin
                role         = ROLE_TOPIC_LEN;
                n_topic_left = topic_val;
                n_body_left  = body_dec;
                if ({12'd0, topic_val} > body_dec) begin
                    bad = 1'b1;
                    if (body_dec == '0) begin
                        pkt_end = 1'b1;
                        n_phase = PH_CTRL;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end else if (topic_val != '0) begin
                    n_phase = PH_TOPIC;
                end else if (body_dec != '0) begin
                    n_phase = PH_PAYLOAD;
                end else begin
                    pkt_end = 1'b1;
                    n_phase = PH_CTRL;
                end
            end
            PH_TOPIC: begin
                role = ROLE_TOPIC;
                if (r_topic_left != '0) begin
                    n_topic_left = r_topic_left - 16'd1;
                end
                n_body_left = body_dec;
                if (body_dec == '0) begin
                    pkt_end = 1'b1;
                    n_phase = PH_CTRL;
                end else if (n_topic_left == '0) begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                role        = ROLE_PAYLOAD;
                n_body_left = body_dec;
                if (body_dec == '0) begin
                    pkt_end = 1'b1;
                    n_phase = PH_CTRL;
                end
            end
            PH_SKIP: begin
                role = ROLE_SKIPPED;
                // CONNACK return code is the second body byte
                if (r_kind == TYPE_CONNACK && r_body_index == 2'd1
                        && i_data_byte == 8'h00 && i_link_up) begin
                    n_session_up = 1'b1;
                end
                if (r_body_index != 2'd3) begin
                    n_body_index = r_body_index + 2'd1;
                end
                n_body_left = body_dec;
                if (body_dec == '0) begin
                    pkt_end = 1'b1;
                    n_phase = PH_CTRL;
                end
            end
            default: begin
                role           = ROLE_CONTROL;
                n_kind         = i_data_byte[7:4];
                n_length_accum = '0;
                n_length_count = '0;
                n_phase        = PH_LEN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_CTRL;
            r_kind         <= '0;
            r_length_accum <= '0;
            r_length_count <= '0;
            r_body_left    <= '0;
            r_topic_left   <= '0;
            r_topic_high   <= '0;
            r_body_index   <= '0;
            r_session_up   <= 1'b0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_kind         <= n_kind;
            r_length_accum <= n_length_accum;
            r_length_count <= n_length_count;
            r_body_left    <= n_body_left;
            r_topic_left   <= n_topic_left;
            r_topic_high   <= n_topic_high;
            r_body_index   <= n_body_index;
            r_session_up   <= n_session_up;
        end
    end

    assign o_result.byte_out   = i_data_byte;
    assign o_result.role       = role;
    assign o_result.msg_type   = n_kind;
    assign o_result.packet_end = pkt_end;
    assign o_result.connected  = n_session_up;
    assign o_result.malformed  = bad;

endmodule

/* rtl/mqtt_packet_deframer.sv */
// MQTT receive deframer top level: input register, parser and result register.
// A byte taken into the input register passes through the parser into the result register; an output stall holds it.
// Throughput: one byte per cycle while the output accepts results; set by the single parser update step.
// Reset (synchronous, active low) empties both registers, closes the session
// and returns the parser to expect a control byte.
module mqtt_packet_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_link_up,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte_out,
    output logic [2:0] o_role,
    output logic [3:0] o_msg_type,
    output logic       o_packet_end,
    output logic       o_connected,
    output logic       o_malformed
);
    import mpd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_link;
    logic       r_out_valid;
    t_result    r_out;
    t_result    step_result;
    logic       out_free;
    logic       step;

    assign out_free = !r_out_valid || i_ready;
    assign step     = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;

    mpd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (r_in_byte),
        .i_link_up   (r_in_link),
        .o_result    (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_link <= i_link_up;
        end
        if (step) begin
            r_out <= step_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_byte_out   = r_out.byte_out;
    assign o_role       = r_out.role;
    assign o_msg_type   = r_out.msg_type;
    assign o_packet_end = r_out.packet_end;
    assign o_connected  = r_out.connected;
    assign o_malformed  = r_out.malformed;

endmodule
